// ===== design/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types and constants of the decimal integer parser.
// ----------------------------------------------------------------------------
package dip_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int DATA_WIDTH  = 64;
   localparam int PROD_WIDTH  = VALUE_WIDTH + 4;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [VALUE_WIDTH-1:0] SIGNED_TOP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK = {VALUE_WIDTH{1'b1}};

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIGNED_MODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_VALUE   = 1'd1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NONE     = 2'd1;
   localparam logic [1:0] ST_OVF      = 2'd2;
   localparam logic [1:0] ST_LEADZERO = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

endpackage

// ===== design/dip_if.sv =====
// ----------------------------------------------------------------------------
// dip_req_if / dip_rsp_if
// Byte input channel and parsed result channel of the decimal integer parser.
// ----------------------------------------------------------------------------
interface dip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface dip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  status;
   logic        byte_taken;

   modport source (output valid, output value, output status, output byte_taken,
                   input ready);
   modport sink   (input valid, input value, input status, input byte_taken,
                   output ready);
endinterface

// ===== design/decimal_integer_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_integer_parser
// Parses ASCII decimal integers, one byte per transaction, with sign handling,
// leading zero rejection and overflow detection against a configured limit.
// Throughput: one byte per cycle while the result channel is not stalled,
// set by the single accumulate step (value*10+digit and its compare with
// the limit) between input and result registers. Reset (synchronous,
// active high) empties both stages, returns the token state to idle and
// sets unsigned mode with an all-ones maximum.
// ----------------------------------------------------------------------------
module decimal_integer_parser
   import dip_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   dip_req_if.sink                    req_chan,
   dip_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DATA_WIDTH-1:0]      csr_write_data
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SIGN,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   // configuration
   logic                   signed_mode_ff;
   logic [VALUE_WIDTH-1:0] umax_ff;

   // input stage
   logic       s1_valid_ff;
   logic [7:0] s1_ch_ff;
   logic       s1_last_ff;

   // token state
   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                   neg_ff, neg_in;
   logic                   ovf_ff, ovf_in;

   // result stage
   logic                  o_valid_ff;
   logic [DATA_WIDTH-1:0] o_value_ff, o_value_in;
   logic [1:0]            o_status_ff, o_status_in;
   logic                  o_taken_ff, o_taken_in;
   logic                  emit;

   logic                   advance;
   logic                   dig;
   logic                   is_sign;
   logic [3:0]             digit;
   logic [VALUE_WIDTH-1:0] limit;
   logic [PROD_WIDTH-1:0]  acc_wide;
   logic [PROD_WIDTH-1:0]  prod;
   logic                   over;
   logic [VALUE_WIDTH-1:0] acc_step;
   logic                   ovf_step;
   logic [VALUE_WIDTH-1:0] signed_val;

   assign advance        = s1_valid_ff & (~o_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | advance;

   assign rsp_chan.valid      = o_valid_ff;
   assign rsp_chan.value      = o_value_ff;
   assign rsp_chan.status     = o_status_ff;
   assign rsp_chan.byte_taken = o_taken_ff;

   assign dig     = (s1_ch_ff >= CH_ZERO) && (s1_ch_ff <= CH_NINE);
   assign is_sign = signed_mode_ff && ((s1_ch_ff == CH_PLUS) || (s1_ch_ff == CH_MINUS));
   assign digit   = dig ? 4'(s1_ch_ff - CH_ZERO) : 4'd0;

   // accumulate step, value*10+digit checked against the limit
   always_comb begin
      if (signed_mode_ff) begin
         limit = neg_ff ? SIGNED_TOP : SIGNED_TOP - VALUE_WIDTH'(1);
      end else begin
         limit = umax_ff;
      end
      acc_wide = PROD_WIDTH'(acc_ff);
      prod     = (acc_wide << 3) + (acc_wide << 1) + PROD_WIDTH'(digit);
      over     = prod > PROD_WIDTH'(limit);
      if (ovf_ff || over) begin
         acc_step = acc_ff;
      end else begin
         acc_step = prod[VALUE_WIDTH-1:0];
      end
      ovf_step = ovf_ff | over;
   end

   // token control
   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;
      o_status_in = ST_OK;
      o_taken_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE, PH_SIGN: begin
            if ((phase_ff == PH_IDLE) && is_sign) begin
               neg_in   = (s1_ch_ff == CH_MINUS);
               phase_in = PH_SIGN;
               if (s1_last_ff) begin
                  emit        = 1'b1;
                  o_status_in = ST_NONE;
               end
            end else if (!dig) begin
               emit        = 1'b1;
               o_status_in = ST_NONE;
            end else begin
               acc_in   = acc_step;
               ovf_in   = ovf_step;
               phase_in = (digit == 4'd0) ? PH_ZERO : PH_DIGITS;
               if (s1_last_ff) begin
                  emit       = 1'b1;
                  o_taken_in = 1'b1;
               end
            end
         end
         PH_ZERO: begin
            emit = 1'b1;
            if (dig) begin
               o_status_in = ST_LEADZERO;
               o_taken_in  = 1'b1;
            end
         end
         PH_DIGITS: begin
            if (!dig) begin
               emit = 1'b1;
            end else begin
               acc_in = acc_step;
               ovf_in = ovf_step;
               if (s1_last_ff) begin
                  emit       = 1'b1;
                  o_taken_in = 1'b1;
               end
            end
         end
      endcase

      if ((o_status_in == ST_OK) && ovf_in) begin
         o_status_in = ST_OVF;
      end
      signed_val = neg_in ? (VALUE_WIDTH'(0) - acc_in) : acc_in;
      o_value_in = (o_status_in == ST_OK) ? DATA_WIDTH'(signed_val) : '0;

      if (emit) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
         umax_ff        <= VALUE_MASK;
         s1_valid_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         ovf_ff         <= 1'b0;
         o_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SIGNED_MODE: signed_mode_ff <= csr_write_data[0];
               CSR_MAX_VALUE: begin
                  if ((csr_write_data >> VALUE_WIDTH) != '0) begin
                     umax_ff <= VALUE_MASK;
                  end else begin
                     umax_ff <= csr_write_data[VALUE_WIDTH-1:0];
                  end
               end
            endcase
         end

         if (req_chan.valid && req_chan.ready) begin
            s1_valid_ff <= 1'b1;
            s1_ch_ff    <= req_chan.ch;
            s1_last_ff  <= req_chan.last;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end

         if (advance) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            ovf_ff   <= ovf_in;
         end

         if (advance && emit) begin
            o_valid_ff  <= 1'b1;
            o_value_ff  <= o_value_in;
            o_status_ff <= o_status_in;
            o_taken_ff  <= o_taken_in;
         end else if (rsp_chan.ready) begin
            o_valid_ff <= 1'b0;
         end
      end
   end

endmodule
